/* hw/rtl/isa_pkg.sv */
// isa_pkg: shared constants, operation and status codes and the cell control type
// for the indexed shift array; depends on nothing, used by isa_cell and the top level
`timescale 1ns / 1ps
`default_nettype none

package isa_pkg;

   // build defaults
   localparam int DEPTH_DEFAULT     = 16;
   localparam int WORD_BITS_DEFAULT = 32;

   // capacity register
   localparam int          CAP_BITS  = 5;
   localparam logic [4:0]  CAP_RESET = 5'd16;

   // operation codes
   localparam int         FUNC_BITS   = 3;
   localparam logic [2:0] FUNC_INSERT = 3'd0;
   localparam logic [2:0] FUNC_APPEND = 3'd1;
   localparam logic [2:0] FUNC_READ   = 3'd2;
   localparam logic [2:0] FUNC_DELETE = 3'd3;
   localparam logic [2:0] FUNC_EDIT   = 3'd4;
   localparam logic [2:0] FUNC_CLEAR  = 3'd5;

   // status codes
   localparam int         STATUS_BITS     = 2;
   localparam logic [1:0] STATUS_DONE     = 2'd0;
   localparam logic [1:0] STATUS_BAD_INDEX = 2'd1;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

   // broadcast to every cell, already qualified by the checks
   typedef struct packed {
      logic ins_en;
      logic del_en;
      logic app_en;
      logic edt_en;
   } isa_op_type;

endpackage

`default_nettype wire

/* hw/rtl/isa_cell.sv */
// isa_cell: one entry of the list, shifting to and from its neighbours
// depends on isa_pkg (isa_op_type)
`timescale 1ns / 1ps
`default_nettype none

module isa_cell #(
   parameter int DEPTH     = isa_pkg::DEPTH_DEFAULT,
   parameter int WORD_BITS = isa_pkg::WORD_BITS_DEFAULT,
   parameter int INDEX     = 0
) (
   input  wire                           clock,
   input  isa_pkg::isa_op_type           op,
   input  wire  [$clog2(DEPTH)-1:0]      position,
   input  wire  [$clog2(DEPTH+1)-1:0]    held,
   input  wire  [WORD_BITS-1:0]          word_in,
   input  wire  [WORD_BITS-1:0]          lower_word,
   input  wire  [WORD_BITS-1:0]          upper_word,
   output logic [WORD_BITS-1:0]          entry
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH+1);
   localparam logic [PW-1:0] MY_POS  = PW'(INDEX);
   localparam logic [CW-1:0] MY_CNT  = CW'(INDEX);
   localparam logic [CW-1:0] NEXT_CNT = CW'(INDEX + 1);

   logic [WORD_BITS-1:0] entry_ff;
   logic [WORD_BITS-1:0] entry_in;
   logic                 take_word;
   logic                 take_lower;
   logic                 take_upper;

   always_comb begin
      take_word  = ((op.ins_en || op.edt_en) && (position == MY_POS)) ||
                   (op.app_en && (held == MY_CNT));
      take_lower = op.ins_en && (MY_POS > position) && (MY_CNT <= held);
      take_upper = op.del_en && (MY_POS >= position) && (NEXT_CNT < held);
      if (take_word) begin
         entry_in = word_in;
      end else if (take_lower) begin
         entry_in = lower_word;
      end else if (take_upper) begin
         entry_in = upper_word;
      end else begin
         entry_in = entry_ff;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

`default_nettype wire

/* hw/rtl/indexed_shift_array.sv */
// indexed_shift_array: ordered list of signed words with insert, append, read,
// delete, edit and clear; depends on isa_pkg and isa_cell
`timescale 1ns / 1ps
`default_nettype none

// An ordered list of up to DEPTH signed words, kept as a row of cells that each
// hold one entry. Every request item is finished in the cycle it is accepted:
// insert moves the cells at and above the index up by one in parallel, delete
// moves the cells above it down by one, append and edit load one cell, read picks
// one cell through a selector and clear zeroes the count. One item is taken per
// clock; the only thing that holds the input back is an unclaimed result sitting
// in the single output register (req_stall follows rsp_stall while a result waits).
// The result carries a status (done, invalid index, overflow), the word read
// (all ones on an invalid read, zero for other requests), the count after the
// request and empty and full flags. The capacity register limits the count and is
// taken as DEPTH when written higher; lowering it below the count keeps the
// entries but makes the list report full. Write it only while the block is idle.

module indexed_shift_array #(
   parameter int DEPTH     = isa_pkg::DEPTH_DEFAULT,
   parameter int WORD_BITS = isa_pkg::WORD_BITS_DEFAULT
) (
   input  wire                                   clock,
   input  wire                                   reset,
   // request items
   input  wire                                   req_valid,
   output logic                                  req_stall,
   input  wire  [isa_pkg::FUNC_BITS-1:0]         req_func,
   input  wire  [$clog2(DEPTH)-1:0]              req_position,
   input  wire  signed [WORD_BITS-1:0]           req_word_in,
   // result items
   output logic                                  rsp_valid,
   input  wire                                   rsp_stall,
   output logic [isa_pkg::STATUS_BITS-1:0]       rsp_status,
   output logic signed [WORD_BITS-1:0]           rsp_word_out,
   output logic [$clog2(DEPTH+1)-1:0]            rsp_fill_count,
   output logic                                  rsp_is_empty,
   output logic                                  rsp_is_full,
   // capacity register
   input  wire                                   csr_valid,
   output logic                                  csr_ready,
   input  wire  [isa_pkg::CAP_BITS-1:0]          csr_data
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH+1);
   // compare width for count against capacity
   localparam int MW = (CW > isa_pkg::CAP_BITS) ? CW : isa_pkg::CAP_BITS;
   localparam logic [MW-1:0] DEPTH_M = MW'(DEPTH);
   localparam logic [CW-1:0] ONE_C   = CW'(1);

   // control and register state
   logic [isa_pkg::CAP_BITS-1:0]    cap_ff;
   logic [CW-1:0]                   held_ff;
   logic [CW-1:0]                   held_in;
   logic                            rsp_valid_ff;
   logic                            rsp_valid_in;

   // result payload registers
   logic [isa_pkg::STATUS_BITS-1:0] status_ff;
   logic [isa_pkg::STATUS_BITS-1:0] status_in;
   logic [WORD_BITS-1:0]            word_out_ff;
   logic [WORD_BITS-1:0]            word_out_in;
   logic                            empty_ff;
   logic                            empty_in;
   logic                            full_ff;
   logic                            full_in;

   // decode
   logic                            accept;
   logic [CW-1:0]                   pos_c;
   logic [MW-1:0]                   cap_m;
   logic [MW-1:0]                   cap_now;
   logic                            full_now;
   logic                            pos_in_list;
   isa_pkg::isa_op_type             op;

   // cell row
   logic [WORD_BITS-1:0]            entry_w [DEPTH];

   assign accept    = req_valid && !req_stall;
   // an unclaimed result blocks the next item
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign csr_ready = 1'b1;

   // capacity saturates at the built depth
   assign cap_m    = MW'(cap_ff);
   assign cap_now  = (cap_m > DEPTH_M) ? DEPTH_M : cap_m;
   assign full_now = MW'(held_ff) >= cap_now;
   assign pos_c    = CW'(req_position);
   // index of an existing entry
   assign pos_in_list = pos_c < held_ff;

   always_comb begin
      op          = '0;
      status_in   = isa_pkg::STATUS_DONE;
      word_out_in = '0;
      held_in     = held_ff;
      if (accept) begin
         case (req_func)
            isa_pkg::FUNC_INSERT: begin
               // index past the end is checked before fullness
               if (pos_c > held_ff) begin
                  status_in = isa_pkg::STATUS_BAD_INDEX;
               end else if (full_now) begin
                  status_in = isa_pkg::STATUS_OVERFLOW;
               end else begin
                  op.ins_en = 1'b1;
                  held_in   = held_ff + ONE_C;
               end
            end
            isa_pkg::FUNC_APPEND: begin
               if (full_now) begin
                  status_in = isa_pkg::STATUS_OVERFLOW;
               end else begin
                  op.app_en = 1'b1;
                  held_in   = held_ff + ONE_C;
               end
            end
            isa_pkg::FUNC_READ: begin
               if (pos_in_list) begin
                  word_out_in = entry_w[req_position];
               end else begin
                  status_in   = isa_pkg::STATUS_BAD_INDEX;
                  word_out_in = '1;
               end
            end
            isa_pkg::FUNC_DELETE: begin
               if (pos_in_list) begin
                  op.del_en = 1'b1;
                  held_in   = held_ff - ONE_C;
               end else begin
                  status_in = isa_pkg::STATUS_BAD_INDEX;
               end
            end
            isa_pkg::FUNC_EDIT: begin
               if (pos_in_list) begin
                  op.edt_en = 1'b1;
               end else begin
                  status_in = isa_pkg::STATUS_BAD_INDEX;
               end
            end
            isa_pkg::FUNC_CLEAR: begin
               // old contents become unreachable
               held_in = '0;
            end
            default: begin
               // unused codes do nothing
            end
         endcase
      end
   end

   assign empty_in     = (held_in == '0);
   assign full_in      = MW'(held_in) >= cap_now;
   // a result stays until taken
   assign rsp_valid_in = accept || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= isa_pkg::CAP_RESET;
         held_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            cap_ff <= csr_data;
         end
         held_ff      <= held_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload, loaded only when an item is accepted
   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff   <= status_in;
         word_out_ff <= word_out_in;
         empty_ff    <= empty_in;
         full_ff     <= full_in;
      end
   end

   // row of cells, each linked to its neighbours
   for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic [WORD_BITS-1:0] lower_w;
      logic [WORD_BITS-1:0] upper_w;
      if (gi == 0) begin : g_first
         assign lower_w = '0;
      end else begin : g_lower
         assign lower_w = entry_w[gi-1];
      end
      if (gi == DEPTH - 1) begin : g_last
         assign upper_w = '0;
      end else begin : g_upper
         assign upper_w = entry_w[gi+1];
      end
      isa_cell #(
         .DEPTH     (DEPTH),
         .WORD_BITS (WORD_BITS),
         .INDEX     (gi)
      ) u_cell (
         .clock      (clock),
         .op         (op),
         .position   (req_position),
         .held       (held_ff),
         .word_in    (req_word_in),
         .lower_word (lower_w),
         .upper_word (upper_w),
         .entry      (entry_w[gi])
      );
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = status_ff;
   assign rsp_word_out   = word_out_ff;
   // count register only moves on accept, so it matches the held result
   assign rsp_fill_count = held_ff;
   assign rsp_is_empty   = empty_ff;
   assign rsp_is_full    = full_ff;

`ifndef SYNTHESIS
   // count never passes the number of cells
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      MW'(held_ff) <= DEPTH_M)
      else $error("fill count above depth");

   // empty flag agrees with the count it reports
   a_empty_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_is_empty == (rsp_fill_count == '0)))
      else $error("empty flag disagrees with fill count");

   // overflow is only reported on a full list
   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == isa_pkg::STATUS_OVERFLOW) |-> rsp_is_full)
      else $error("overflow reported on a list that is not full");

   // apart from clear, an item moves the count by at most one
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (accept && req_func != isa_pkg::FUNC_CLEAR) |=>
         (held_ff == $past(held_ff) || held_ff == $past(held_ff) + ONE_C ||
          held_ff + ONE_C == $past(held_ff)))
      else $error("count moved by more than one");
`endif

endmodule

`default_nettype wire

/* sim/tb_indexed_shift_array.sv */
// tb_indexed_shift_array: self-checking bench for the ordered list block, with a directed
// table, random list traffic, capacity changes and random idling on both channels
// depends on isa_pkg and indexed_shift_array
`timescale 1ns / 1ps

module tb_indexed_shift_array;

   localparam int DEPTH          = isa_pkg::DEPTH_DEFAULT;
   localparam int WORD_BITS      = isa_pkg::WORD_BITS_DEFAULT;
   localparam int POS_BITS       = $clog2(DEPTH);
   localparam int COUNT_BITS     = $clog2(DEPTH + 1);
   localparam int IDLE_PERCENT   = 26;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int TAIL_CYCLES    = 8;

   // func codes the block treats as no operation
   localparam logic [isa_pkg::FUNC_BITS-1:0] FUNC_SPARE_LO = 3'd6;
   localparam logic [isa_pkg::FUNC_BITS-1:0] FUNC_SPARE_HI = 3'd7;

   // word returned by a read at an invalid index
   localparam logic [WORD_BITS-1:0] BAD_READ_WORD = '1;

   typedef struct packed {
      logic [isa_pkg::FUNC_BITS-1:0] func;
      logic [POS_BITS-1:0]           position;
      logic [WORD_BITS-1:0]          word;
   } list_request_type;

   typedef struct packed {
      logic [isa_pkg::STATUS_BITS-1:0] status;
      logic [WORD_BITS-1:0]            word;
      logic [COUNT_BITS-1:0]           count;
      logic                            empty;
      logic                            full;
   } list_outcome_type;

   // one directed item; the outcome is only typed in where it is obvious
   typedef struct packed {
      logic             typed;
      list_request_type rq;
      list_outcome_type want;
   } table_row_type;

   logic clock;
   logic reset = 1'b1;

   logic                            req_valid    = 1'b0;
   logic                            req_stall;
   logic [isa_pkg::FUNC_BITS-1:0]   req_func     = '0;
   logic [POS_BITS-1:0]             req_position = '0;
   logic signed [WORD_BITS-1:0]     req_word_in  = '0;

   logic                            rsp_valid;
   logic                            rsp_stall    = 1'b0;
   logic [isa_pkg::STATUS_BITS-1:0] rsp_status;
   logic signed [WORD_BITS-1:0]     rsp_word_out;
   logic [COUNT_BITS-1:0]           rsp_fill_count;
   logic                            rsp_is_empty;
   logic                            rsp_is_full;

   logic                            csr_valid    = 1'b0;
   logic                            csr_ready;
   logic [isa_pkg::CAP_BITS-1:0]    csr_data     = '0;

   // shadow copy of the list held by the block
   logic [WORD_BITS-1:0]         list_words [DEPTH];
   int unsigned                  list_count   = 0;
   logic [isa_pkg::CAP_BITS-1:0] capacity_reg = isa_pkg::CAP_RESET;
   bit                           growing      = 1'b1;
   bit                           calm         = 1'b0;

   list_outcome_type pending_outcomes [$];
   table_row_type    directed_rows [$];
   int unsigned      mismatches   = 0;
   int unsigned      quiet_cycles = 0;

   indexed_shift_array dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_func       (req_func),
      .req_position   (req_position),
      .req_word_in    (req_word_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_word_out   (rsp_word_out),
      .rsp_fill_count (rsp_fill_count),
      .rsp_is_empty   (rsp_is_empty),
      .rsp_is_full    (rsp_is_full),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_data       (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // capacity as the block applies it: anything above the depth saturates
   function automatic int unsigned capacity_limit();
      return (capacity_reg > DEPTH) ? DEPTH : capacity_reg;
   endfunction

   // carries out one request on the shadow list and gives the result it must produce
   function automatic list_outcome_type predict_list_op(input list_request_type rq);
      list_outcome_type res;
      int               slot;
      bit               full_now;
      res      = '0;
      full_now = (list_count >= capacity_limit());
      case (rq.func)
         isa_pkg::FUNC_INSERT: begin
            // a bad index wins over overflow
            if (rq.position > list_count) begin
               res.status = isa_pkg::STATUS_BAD_INDEX;
            end else if (full_now) begin
               res.status = isa_pkg::STATUS_OVERFLOW;
            end else begin
               for (slot = list_count; slot > rq.position; slot--)
                  if (slot < DEPTH) list_words[slot] = list_words[slot - 1];
               list_words[rq.position] = rq.word;
               list_count++;
            end
         end
         isa_pkg::FUNC_APPEND: begin
            if (full_now) begin
               res.status = isa_pkg::STATUS_OVERFLOW;
            end else begin
               if (list_count < DEPTH) list_words[list_count] = rq.word;
               list_count++;
            end
         end
         isa_pkg::FUNC_READ: begin
            if (rq.position >= list_count) begin
               res.status = isa_pkg::STATUS_BAD_INDEX;
               res.word   = BAD_READ_WORD;
            end else begin
               res.word = list_words[rq.position];
            end
         end
         isa_pkg::FUNC_DELETE: begin
            if (rq.position >= list_count) begin
               res.status = isa_pkg::STATUS_BAD_INDEX;
            end else begin
               for (slot = rq.position; slot + 1 < list_count; slot++)
                  list_words[slot] = list_words[slot + 1];
               list_count--;
            end
         end
         isa_pkg::FUNC_EDIT: begin
            if (rq.position >= list_count) res.status = isa_pkg::STATUS_BAD_INDEX;
            else list_words[rq.position] = rq.word;
         end
         isa_pkg::FUNC_CLEAR: list_count = 0;
         default: ;
      endcase
      res.count = COUNT_BITS'(list_count);
      res.empty = (list_count == 0);
      res.full  = (list_count >= capacity_limit());
      return res;
   endfunction

   // random traffic that swings the list between empty and full, so that overflow,
   // shifting across the whole row and bad indexes all come up again and again
   function automatic list_request_type next_list_request();
      list_request_type rq;
      int unsigned      roll;
      int               hi;
      if (list_count >= capacity_limit()) growing = 1'b0;
      else if (list_count == 0) growing = 1'b1;
      roll = $urandom_range(0, 99);
      if (roll < 2) begin
         rq.func = $urandom_range(0, 1) ? FUNC_SPARE_HI : FUNC_SPARE_LO;
      end else if (roll < 3) begin
         rq.func = isa_pkg::FUNC_CLEAR;
      end else begin
         roll = $urandom_range(0, 95);
         if (growing)
            rq.func = (roll < 26) ? isa_pkg::FUNC_INSERT : (roll < 48) ? isa_pkg::FUNC_APPEND :
                      (roll < 66) ? isa_pkg::FUNC_READ   :
                      (roll < 80) ? isa_pkg::FUNC_DELETE : isa_pkg::FUNC_EDIT;
         else
            rq.func = (roll < 12) ? isa_pkg::FUNC_INSERT : (roll < 22) ? isa_pkg::FUNC_APPEND :
                      (roll < 42) ? isa_pkg::FUNC_READ   :
                      (roll < 76) ? isa_pkg::FUNC_DELETE : isa_pkg::FUNC_EDIT;
      end
      // mostly in range, now and then anywhere in the field
      hi = (rq.func == isa_pkg::FUNC_INSERT) ? int'(list_count) : int'(list_count) - 1;
      if (hi < 0) hi = 0;
      if (hi > DEPTH - 1) hi = DEPTH - 1;
      if ($urandom_range(0, 99) < 85) rq.position = POS_BITS'($urandom_range(0, hi));
      else rq.position = POS_BITS'($urandom_range(0, DEPTH - 1));
      case ($urandom_range(0, 11))
         0:       rq.word = {1'b0, {(WORD_BITS - 1){1'b1}}};
         1:       rq.word = {1'b1, {(WORD_BITS - 1){1'b0}}};
         2:       rq.word = '0;
         3:       rq.word = '1;
         default: rq.word = $urandom;
      endcase
      return rq;
   endfunction

   task automatic add_row(input logic typed, input logic [isa_pkg::FUNC_BITS-1:0] f,
                          input logic [POS_BITS-1:0] p, input logic [WORD_BITS-1:0] w,
                          input list_outcome_type want);
      table_row_type row;
      row.typed       = typed;
      row.rq.func     = f;
      row.rq.position = p;
      row.rq.word     = w;
      row.want        = want;
      directed_rows.push_back(row);
   endtask

   // called just after a rising edge; leaves valid high once the item is taken
   task automatic send_request(input list_request_type rq, input logic typed,
                               input list_outcome_type want);
      list_outcome_type predicted;
      while (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_func     <= rq.func;
      req_position <= rq.position;
      req_word_in  <= rq.word;
      do @(posedge clock); while (req_stall);
      predicted = predict_list_op(rq);
      pending_outcomes.push_back(typed ? want : predicted);
   endtask

   // hold off the sender until every result is back
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_outcomes.size() != 0);
   endtask

   // capacity change on an idle block, then a run of random items
   task automatic run_phase(input logic [isa_pkg::CAP_BITS-1:0] cap, input int items);
      drain_results();
      csr_valid <= 1'b1;
      csr_data  <= cap;
      do @(posedge clock); while (!csr_ready);
      capacity_reg = cap;
      csr_valid   <= 1'b0;
      repeat (items) send_request(next_list_request(), 1'b0, '0);
   endtask

   task automatic note_field(input string name, input logic [WORD_BITS-1:0] want_v,
                             input logic [WORD_BITS-1:0] got_v);
      if (want_v !== got_v) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %h, got %h", $time, name, want_v, got_v);
      end
   endtask

   // result checker: every taken item against the oldest outstanding expectation
   always @(posedge clock) begin : check_results
      list_outcome_type want;
      list_outcome_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_status, rsp_word_out, rsp_fill_count, rsp_is_empty, rsp_is_full};
         if (pending_outcomes.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected result, expected none, got %h", $time, got);
         end else begin
            want = pending_outcomes.pop_front();
            note_field("status", want.status, got.status);
            note_field("word_out", want.word, got.word);
            note_field("fill_count", want.count, got.count);
            note_field("is_empty", want.empty, got.empty);
            note_field("is_full", want.full, got.full);
         end
      end
   end

   // result side back-pressure, switched off during the calm stretch
   always @(posedge clock)
      rsp_stall <= !calm && ($urandom_range(0, 99) < IDLE_PERCENT);

   // cycles with no handshake on any channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      wait (quiet_cycles == WATCHDOG_LIMIT);
      $display("indexed_shift_array test failed");
      $finish;
   end

   initial begin
      foreach (list_words[i]) list_words[i] = '0;

      // directed table, starting from the reset capacity of sixteen
      // empty list: every indexed request is a bad index
      add_row(1'b1, isa_pkg::FUNC_READ,   4'd0, 32'h0000_0000,
              {isa_pkg::STATUS_BAD_INDEX, BAD_READ_WORD, 5'd0, 1'b1, 1'b0});
      add_row(1'b1, isa_pkg::FUNC_DELETE, 4'd0, 32'h0000_0000,
              {isa_pkg::STATUS_BAD_INDEX, 32'h0, 5'd0, 1'b1, 1'b0});
      add_row(1'b1, isa_pkg::FUNC_EDIT,   4'd0, 32'h0000_0001,
              {isa_pkg::STATUS_BAD_INDEX, 32'h0, 5'd0, 1'b1, 1'b0});
      // insert past the count
      add_row(1'b1, isa_pkg::FUNC_INSERT, 4'd1, 32'h0000_0005,
              {isa_pkg::STATUS_BAD_INDEX, 32'h0, 5'd0, 1'b1, 1'b0});
      // extreme words going in
      add_row(1'b1, isa_pkg::FUNC_INSERT, 4'd0, 32'h7FFF_FFFF,
              {isa_pkg::STATUS_DONE, 32'h0, 5'd1, 1'b0, 1'b0});
      add_row(1'b1, isa_pkg::FUNC_APPEND, 4'd15, 32'h8000_0000,
              {isa_pkg::STATUS_DONE, 32'h0, 5'd2, 1'b0, 1'b0});
      // inserts in the middle and at the front shift the rest up
      add_row(1'b0, isa_pkg::FUNC_INSERT, 4'd1, 32'hFFFF_FFFF, '0);
      add_row(1'b0, isa_pkg::FUNC_INSERT, 4'd0, 32'h0000_0000, '0);
      add_row(1'b0, isa_pkg::FUNC_READ,   4'd0, 32'h0000_0000, '0);
      add_row(1'b0, isa_pkg::FUNC_READ,   4'd1, 32'h0000_0000, '0);
      add_row(1'b0, isa_pkg::FUNC_READ,   4'd2, 32'h0000_0000, '0);
      add_row(1'b0, isa_pkg::FUNC_READ,   4'd3, 32'h0000_0000, '0);
      add_row(1'b0, isa_pkg::FUNC_EDIT,   4'd3, 32'hA5A5_A5A5, '0);
      add_row(1'b0, isa_pkg::FUNC_READ,   4'd3, 32'h0000_0000, '0);
      // read at the count
      add_row(1'b1, isa_pkg::FUNC_READ,   4'd4, 32'h0000_0000,
              {isa_pkg::STATUS_BAD_INDEX, BAD_READ_WORD, 5'd4, 1'b0, 1'b0});
      // delete in the middle, then the last entry
      add_row(1'b0, isa_pkg::FUNC_DELETE, 4'd1, 32'h0000_0000, '0);
      add_row(1'b0, isa_pkg::FUNC_READ,   4'd1, 32'h0000_0000, '0);
      add_row(1'b0, isa_pkg::FUNC_DELETE, 4'd2, 32'h0000_0000, '0);
      // spare func codes do nothing
      add_row(1'b0, FUNC_SPARE_LO, 4'd15, 32'h1234_5678, '0);
      add_row(1'b0, FUNC_SPARE_HI, 4'd0,  32'hFFFF_FFFF, '0);
      add_row(1'b0, isa_pkg::FUNC_INSERT, 4'd15, 32'h0000_0001, '0);
      // clear, then the list behaves as new
      add_row(1'b1, isa_pkg::FUNC_CLEAR,  4'd0, 32'h0000_0000,
              {isa_pkg::STATUS_DONE, 32'h0, 5'd0, 1'b1, 1'b0});
      add_row(1'b1, isa_pkg::FUNC_READ,   4'd0, 32'h0000_0000,
              {isa_pkg::STATUS_BAD_INDEX, BAD_READ_WORD, 5'd0, 1'b1, 1'b0});
      add_row(1'b1, isa_pkg::FUNC_APPEND, 4'd0, 32'h0000_0000,
              {isa_pkg::STATUS_DONE, 32'h0, 5'd1, 1'b0, 1'b0});

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         send_request(directed_rows[i].rq, directed_rows[i].typed, directed_rows[i].want);

      // capacity above depth saturates at sixteen
      run_phase(5'd31, 150);
      // fill up, then lower the capacity below the count without clearing
      while (list_count < 12)
         send_request('{func: isa_pkg::FUNC_APPEND, position: '0, word: $urandom}, 1'b0, '0);
      run_phase(5'd3, 80);
      // capacity zero: always full
      run_phase(5'd0, 40);
      run_phase(5'd1, 60);
      // long stretch with no idling on either side
      calm = 1'b1;
      run_phase(5'd16, 200);
      calm = 1'b0;
      run_phase(5'd17, 120);
      run_phase(5'd8, 100);
      repeat (5) run_phase(isa_pkg::CAP_BITS'($urandom_range(0, 31)), 60);

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatches == 0 && pending_outcomes.size() == 0)
         $display("indexed_shift_array test passed");
      else
         $display("indexed_shift_array test failed");
      $finish;
   end

endmodule
